>>> rtl/deq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue package
// Depth, index widths, command and status codes, and channel payload types.
// ----------------------------------------------------------------------------
package deq_pkg;

   localparam int DEPTH = 16;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;

   typedef enum logic [2:0] {
      CMD_PUSH_FRONT = 3'd0,
      CMD_PUSH_BACK  = 3'd1,
      CMD_POP_FRONT  = 3'd2,
      CMD_POP_BACK   = 3'd3,
      CMD_PEEK_FRONT = 3'd4,
      CMD_PEEK_BACK  = 3'd5,
      CMD_CLEAR      = 3'd6
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic [2:0]               command;
      logic signed [DATA_W-1:0] value_in;
   } req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic signed [DATA_W-1:0] read_value;
      logic                     is_empty;
      logic [CNT_W-1:0]         fill_level;
   } rsp_type;

endpackage

>>> rtl/double_ended_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue
// Bounded deque of signed words in a ring store with front index and count.
// ----------------------------------------------------------------------------
// Result path: an item's result is registered in the read stage (store read),
//   then in the output register; both hold while the result side stalls.
// Throughput: one item per cycle while the result side keeps up; front index and
//   count update at transfer, so the single store port is used once per item.
// Reset clears front index, count and all valid flags; the store is not cleared.
module double_ended_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  deq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output deq_pkg::rsp_type rsp_data
);
   import deq_pkg::*;

   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
   localparam logic [CNT_W:0]   DEPTH_SUM = (CNT_W + 1)'(DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);

   logic [DATA_W-1:0] mem [DEPTH];

   logic [IDX_W-1:0] front_ff, front_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // read stage
   logic             s1_valid_ff;
   logic             s1_read_ff;
   status_type       s1_status_ff;
   logic [CNT_W-1:0] s1_count_ff;
   logic [DATA_W-1:0] rd_data_ff;

   // output register
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   logic             accept, s1_advance;
   logic             is_full, is_zero;
   logic             wr_en, rd_en;
   logic [IDX_W-1:0] wr_addr, rd_addr;
   logic [IDX_W-1:0] front_dec, front_inc, back_next, back_top;
   logic [CNT_W:0]   sum_next, sum_top;
   status_type       status_in;
   cmd_type          cmd;

   assign s1_advance = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = s1_valid_ff && !s1_advance;
   assign accept     = req_valid && !req_stall;
   assign cmd        = cmd_type'(req_data.command);

   assign is_full = (count_ff == DEPTH_CNT);
   assign is_zero = (count_ff == '0);

   assign front_dec = (front_ff == '0) ? LAST_IDX : front_ff - 1'b1;
   assign front_inc = (front_ff == LAST_IDX) ? '0 : front_ff + 1'b1;

   // wrap front + count and front + count - 1 into the ring
   always_comb begin
      sum_next = (CNT_W + 1)'(front_ff) + (CNT_W + 1)'(count_ff);
      sum_top  = sum_next - 1'b1;
      if (sum_next >= DEPTH_SUM) begin
         sum_next = sum_next - DEPTH_SUM;
      end
      if (sum_top >= DEPTH_SUM) begin
         sum_top = sum_top - DEPTH_SUM;
      end
      back_next = sum_next[IDX_W-1:0];
      back_top  = sum_top[IDX_W-1:0];
   end

   always_comb begin
      front_in  = front_ff;
      count_in  = count_ff;
      status_in = ST_OK;
      wr_en     = 1'b0;
      wr_addr   = back_next;
      rd_en     = 1'b0;
      rd_addr   = front_ff;
      unique case (cmd) inside
         CMD_PUSH_FRONT: begin
            if (is_full) begin
               status_in = ST_FULL;
            end else begin
               front_in = front_dec;
               count_in = count_ff + 1'b1;
               wr_en    = 1'b1;
               wr_addr  = front_dec;
            end
         end
         CMD_PUSH_BACK: begin
            if (is_full) begin
               status_in = ST_FULL;
            end else begin
               count_in = count_ff + 1'b1;
               wr_en    = 1'b1;
               wr_addr  = back_next;
            end
         end
         CMD_POP_FRONT, CMD_PEEK_FRONT: begin
            if (is_zero) begin
               status_in = ST_EMPTY;
            end else begin
               rd_en   = 1'b1;
               rd_addr = front_ff;
               if (cmd == CMD_POP_FRONT) begin
                  front_in = front_inc;
                  count_in = count_ff - 1'b1;
               end
            end
         end
         CMD_POP_BACK, CMD_PEEK_BACK: begin
            if (is_zero) begin
               status_in = ST_EMPTY;
            end else begin
               rd_en   = 1'b1;
               rd_addr = back_top;
               if (cmd == CMD_POP_BACK) begin
                  count_in = count_ff - 1'b1;
               end
            end
         end
         CMD_CLEAR: begin
            front_in = '0;
            count_in = '0;
         end
         default: begin
         end
      endcase
   end

   // ring store: one write or one read per transfer
   always_ff @(posedge clock) begin
      if (accept && wr_en) begin
         mem[wr_addr] <= req_data.value_in;
      end
      if (accept && rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         count_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            front_ff <= front_in;
            count_ff <= count_in;
         end
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_advance) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_read_ff   <= rd_en;
         s1_status_ff <= status_in;
         s1_count_ff  <= count_in;
      end
      if (s1_advance && s1_valid_ff) begin
         rsp_data_ff.status     <= s1_status_ff;
         rsp_data_ff.read_value <= s1_read_ff ? rd_data_ff : '0;
         rsp_data_ff.is_empty   <= (s1_count_ff == '0);
         rsp_data_ff.fill_level <= s1_count_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("entry count exceeds depth");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_advance) |=> (s1_valid_ff && $stable(s1_count_ff)))
      else $error("read stage dropped a held item");

   a_full_level: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_FULL) |-> (rsp_data.fill_level == DEPTH_CNT))
      else $error("full status with queue not full");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.is_empty == (rsp_data.fill_level == '0)))
      else $error("empty flag disagrees with fill level");

   a_no_read_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ST_OK) |-> (rsp_data.read_value == '0))
      else $error("read value on failed command");

endmodule
